// ===== hw/rtl/lcfr_pkg.sv =====
// Shared types and constants for the linear chain flow rule resolver.
// No dependencies; used by the interfaces, the switch table and the top level.

package lcfr_pkg;

  // Fixed field widths
  localparam int ID_W       = 3;
  localparam int NB_W       = 4;
  localparam int ID_MAX     = 7;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_SWITCHES = 1'b0;
  localparam logic [ID_W-1:0]      NUM_SW_RESET     = 3'd7;

  // Message function codes
  localparam logic FUNC_OPEN  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_FWD  = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PORT_NONE  = 2'd0,
    PORT_LEFT  = 2'd1,
    PORT_RIGHT = 2'd2,
    PORT_LOCAL = 2'd3
  } port_e;

  // Switch table access request
  typedef struct packed {
    logic            wr_en;
    logic [ID_W-1:0] wr_id;
    logic            rd_en;
    logic [ID_W-1:0] rd_id;
  } tbl_cmd_t;

endpackage

// ===== hw/rtl/lcfr_if.sv =====
// Valid/ready stream interfaces for request and reply beats.
// Depends on lcfr_pkg for the fixed field widths.

interface lcfr_in_if import lcfr_pkg::*; #(
  parameter int IP_WIDTH = 10
) ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [ID_W-1:0]        switch_id;
  logic signed [NB_W-1:0] left_neighbor;
  logic signed [NB_W-1:0] right_neighbor;
  logic [IP_WIDTH-1:0]    range_lo;
  logic [IP_WIDTH-1:0]    range_hi;
  logic [IP_WIDTH-1:0]    dest_ip;

  modport source (
    output valid, func, switch_id, left_neighbor, right_neighbor, range_lo, range_hi, dest_ip,
    input  ready
  );
  modport sink (
    input  valid, func, switch_id, left_neighbor, right_neighbor, range_lo, range_hi, dest_ip,
    output ready
  );
endinterface

interface lcfr_out_if import lcfr_pkg::*; #(
  parameter int IP_WIDTH = 10
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          reply_kind;
  logic [ID_W-1:0]     target_switch;
  logic [IP_WIDTH-1:0] rule_lo;
  logic [IP_WIDTH-1:0] rule_hi;
  logic [1:0]          out_port;

  modport source (
    output valid, reply_kind, target_switch, rule_lo, rule_hi, out_port,
    input  ready
  );
  modport sink (
    input  valid, reply_kind, target_switch, rule_lo, rule_hi, out_port,
    output ready
  );
endinterface

// ===== hw/rtl/lcfr_table.sv =====
// Switch table: one-read one-write synchronous memory plus per-entry active flags.
// Depends on lcfr_pkg for the access request struct.

module lcfr_table import lcfr_pkg::*; #(
  parameter int MAX_SWITCHES = 7,
  parameter int ENTRY_W      = 28
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbl_cmd_t                cmd_i,
  input  logic [ENTRY_W-1:0]      wr_data_i,
  output logic [ENTRY_W-1:0]      rd_data_o,
  output logic [MAX_SWITCHES-1:0] active_o
);

  localparam int AW = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;

  logic [ENTRY_W-1:0]      mem [MAX_SWITCHES];
  logic [ENTRY_W-1:0]      rd_data_q;
  logic [MAX_SWITCHES-1:0] active_q;
  logic [AW-1:0]           wr_idx;
  logic [AW-1:0]           rd_idx;

  // Switch numbers start at one
  assign wr_idx = AW'(cmd_i.wr_id - ID_W'(1));
  assign rd_idx = AW'(cmd_i.rd_id - ID_W'(1));

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_idx] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_idx];
    end
  end

  // Mark an entry active once written; reset leaves all inactive
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.wr_en) begin
      active_q[wr_idx] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;
  assign active_o  = active_q;

endmodule

// ===== hw/rtl/linear_chain_flow_rule_resolver_top.sv =====
// Top level of the linear chain flow rule resolver: sequencer, config register, reply buffer.
// Depends on lcfr_pkg, lcfr_if and lcfr_table.
//
//  channel | dir | handshake              | beat contents
//  --------+-----+------------------------+------------------------------------------------
//  in_i    | in  | valid/ready            | func, switch_id, neighbors, range, dest_ip
//  out_o   | out | valid/ready            | reply_kind, target_switch, rule_lo/hi, out_port
//  apb     | in  | psel/penable, pready=1 | num_switches at byte address 0
//
// An open beat writes its table entry, if present, on accept and goes straight to the reply.
// A query searches up to num_switches entries for the owner, checks its own entry, then walks
// up to 2*MAX_SWITCHES steps over both directions; the table's single read port visits one
// entry per cycle. Reset clears all entries to inactive at once, with no sweep.
// The reply waits in an output register; a new beat is accepted as soon as the sequencer
// has handed its reply to that register.

module linear_chain_flow_rule_resolver_top import lcfr_pkg::*; #(
  parameter int MAX_SWITCHES = 7,
  parameter int IP_WIDTH     = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lcfr_in_if.sink               in_i,
  lcfr_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW   = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;
  localparam int SW   = $clog2(MAX_SWITCHES + 1);
  localparam int EW   = 2 * NB_W + 2 * IP_WIDTH;
  localparam int CapN = (MAX_SWITCHES < ID_MAX) ? MAX_SWITCHES : ID_MAX;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OWNER,
    ST_ME,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [ID_W-1:0]        num_q, num_d;
  logic [ID_W-1:0]        present_n;
  logic [ID_W-1:0]        id_q, id_d;
  logic [ID_W-1:0]        idx_q, idx_d;
  logic [SW-1:0]          steps_q, steps_d;
  logic                   dir_right_q, dir_right_d;
  logic [IP_WIDTH-1:0]    ip_q, ip_d;
  logic signed [NB_W-1:0] me_left_q, me_left_d;
  kind_e                  kind_q, kind_d;
  port_e                  port_q, port_d;
  logic [IP_WIDTH-1:0]    lo_q, lo_d;
  logic [IP_WIDTH-1:0]    hi_q, hi_d;
  logic                   out_valid_q, out_valid_d;
  kind_e                  out_kind_q, out_kind_d;
  port_e                  out_port_q, out_port_d;
  logic [ID_W-1:0]        out_id_q, out_id_d;
  logic [IP_WIDTH-1:0]    out_lo_q, out_lo_d;
  logic [IP_WIDTH-1:0]    out_hi_q, out_hi_d;

  tbl_cmd_t               tbl_cmd;
  logic [EW-1:0]          wr_data;
  logic [EW-1:0]          rd_data;
  logic [MAX_SWITCHES-1:0] active;
  logic signed [NB_W-1:0] rd_left;
  logic signed [NB_W-1:0] rd_right;
  logic signed [NB_W-1:0] nxt;
  logic [IP_WIDTH-1:0]    rd_lo;
  logic [IP_WIDTH-1:0]    rd_hi;
  logic                   cur_act;
  logic                   owns_rd;
  logic                   in_fire;
  logic                   cfg_wr;

  // Entry is present in the chain
  function automatic logic is_present(logic [ID_W-1:0] id, logic [ID_W-1:0] n);
    return (id != '0) && (id <= n);
  endfunction

  // Entry is present and has been opened
  function automatic logic id_ok(logic [ID_W-1:0] id, logic [ID_W-1:0] n,
                                 logic [MAX_SWITCHES-1:0] act);
    return is_present(id, n) && act[AW'(id - ID_W'(1))];
  endfunction

  // Neighbor continues a walk; a negative value ends it
  function automatic logic nb_ok(logic signed [NB_W-1:0] nb, logic [ID_W-1:0] n,
                                 logic [MAX_SWITCHES-1:0] act);
    return !nb[NB_W-1] && id_ok(nb[ID_W-1:0], n, act);
  endfunction

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[APB_ADDR_W-1:2] == REG_NUM_SWITCHES);
  assign num_d  = cfg_wr ? pwdata[ID_W-1:0] : num_q;
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_NUM_SWITCHES)
                  ? {{(APB_DATA_W-ID_W){1'b0}}, num_q} : '0;

  // Clamp the switch count to the table depth
  assign present_n = (num_q > ID_W'(CapN)) ? ID_W'(CapN) : num_q;

  // Switch table
  lcfr_table #(
    .MAX_SWITCHES (MAX_SWITCHES),
    .ENTRY_W      (EW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data),
    .active_o  (active)
  );

  assign wr_data  = {in_i.left_neighbor, in_i.right_neighbor, in_i.range_lo, in_i.range_hi};
  assign rd_left  = rd_data[EW-1 -: NB_W];
  assign rd_right = rd_data[EW-1-NB_W -: NB_W];
  assign rd_lo    = rd_data[2*IP_WIDTH-1 -: IP_WIDTH];
  assign rd_hi    = rd_data[IP_WIDTH-1:0];

  // Entry under evaluation holds the destination
  assign cur_act = active[AW'(idx_q - ID_W'(1))];
  assign owns_rd = cur_act && (ip_q >= rd_lo) && (ip_q <= rd_hi);
  assign nxt     = dir_right_q ? rd_right : rd_left;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Sequencer: owner search, own range check, right walk, then left walk.
  // Table writes only happen on an accepted open beat, never during a query,
  // so reads and writes to one entry cannot overlap.
  always_comb begin
    state_d     = state_q;
    id_d        = id_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    dir_right_d = dir_right_q;
    ip_d        = ip_q;
    me_left_d   = me_left_q;
    kind_d      = kind_q;
    port_d      = port_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_port_d  = out_port_q;
    out_id_d    = out_id_q;
    out_lo_d    = out_lo_q;
    out_hi_d    = out_hi_q;
    tbl_cmd     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          id_d   = in_i.switch_id;
          ip_d   = in_i.dest_ip;
          port_d = PORT_NONE;
          if (in_i.func == FUNC_OPEN) begin
            tbl_cmd.wr_en = is_present(in_i.switch_id, present_n);
            tbl_cmd.wr_id = in_i.switch_id;
            kind_d        = KIND_ACK;
            lo_d          = '0;
            hi_d          = '0;
            state_d       = ST_DONE;
          end else if (present_n == '0) begin
            kind_d  = KIND_DROP;
            lo_d    = in_i.dest_ip;
            hi_d    = in_i.dest_ip;
            state_d = ST_DONE;
          end else begin
            tbl_cmd.rd_en = 1'b1;
            tbl_cmd.rd_id = ID_W'(1);
            idx_d         = ID_W'(1);
            state_d       = ST_OWNER;
          end
        end
      end
      ST_OWNER: begin
        if (owns_rd) begin
          // Lowest-numbered owner sets the rule range
          lo_d = rd_lo;
          hi_d = rd_hi;
          if (id_ok(id_q, present_n, active)) begin
            tbl_cmd.rd_en = 1'b1;
            tbl_cmd.rd_id = id_q;
            idx_d         = id_q;
            state_d       = ST_ME;
          end else begin
            kind_d  = KIND_DROP;
            state_d = ST_DONE;
          end
        end else if (idx_q == present_n) begin
          // Unknown destination: drop the single address
          kind_d  = KIND_DROP;
          lo_d    = ip_q;
          hi_d    = ip_q;
          state_d = ST_DONE;
        end else begin
          tbl_cmd.rd_en = 1'b1;
          tbl_cmd.rd_id = idx_q + ID_W'(1);
          idx_d         = idx_q + ID_W'(1);
        end
      end
      ST_ME: begin
        me_left_d = rd_left;
        if (owns_rd) begin
          kind_d  = KIND_FWD;
          port_d  = PORT_LOCAL;
          lo_d    = rd_lo;
          hi_d    = rd_hi;
          state_d = ST_DONE;
        end else if (nb_ok(rd_right, present_n, active)) begin
          tbl_cmd.rd_en = 1'b1;
          tbl_cmd.rd_id = rd_right[ID_W-1:0];
          idx_d         = rd_right[ID_W-1:0];
          steps_d       = SW'(1);
          dir_right_d   = 1'b1;
          state_d       = ST_WALK;
        end else if (nb_ok(rd_left, present_n, active)) begin
          tbl_cmd.rd_en = 1'b1;
          tbl_cmd.rd_id = rd_left[ID_W-1:0];
          idx_d         = rd_left[ID_W-1:0];
          steps_d       = SW'(1);
          dir_right_d   = 1'b0;
          state_d       = ST_WALK;
        end else begin
          kind_d  = KIND_DROP;
          state_d = ST_DONE;
        end
      end
      ST_WALK: begin
        if (owns_rd) begin
          kind_d  = KIND_FWD;
          port_d  = dir_right_q ? PORT_RIGHT : PORT_LEFT;
          state_d = ST_DONE;
        end else if ((steps_q != SW'(MAX_SWITCHES)) && nb_ok(nxt, present_n, active)) begin
          tbl_cmd.rd_en = 1'b1;
          tbl_cmd.rd_id = nxt[ID_W-1:0];
          idx_d         = nxt[ID_W-1:0];
          steps_d       = steps_q + SW'(1);
        end else if (dir_right_q && nb_ok(me_left_q, present_n, active)) begin
          // Right side failed: try the left side
          tbl_cmd.rd_en = 1'b1;
          tbl_cmd.rd_id = me_left_q[ID_W-1:0];
          idx_d         = me_left_q[ID_W-1:0];
          steps_d       = SW'(1);
          dir_right_d   = 1'b0;
        end else begin
          kind_d  = KIND_DROP;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the reply to the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_port_d  = port_q;
          out_id_d    = id_q;
          out_lo_d    = lo_q;
          out_hi_d    = hi_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, config and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= NUM_SW_RESET;
      id_q        <= '0;
      idx_q       <= '0;
      steps_q     <= '0;
      dir_right_q <= 1'b0;
      ip_q        <= '0;
      me_left_q   <= '0;
      kind_q      <= KIND_ACK;
      port_q      <= PORT_NONE;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_ACK;
      out_port_q  <= PORT_NONE;
      out_id_q    <= '0;
      out_lo_q    <= '0;
      out_hi_q    <= '0;
    end else begin
      state_q     <= state_d;
      num_q       <= num_d;
      id_q        <= id_d;
      idx_q       <= idx_d;
      steps_q     <= steps_d;
      dir_right_q <= dir_right_d;
      ip_q        <= ip_d;
      me_left_q   <= me_left_d;
      kind_q      <= kind_d;
      port_q      <= port_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_port_q  <= out_port_d;
      out_id_q    <= out_id_d;
      out_lo_q    <= out_lo_d;
      out_hi_q    <= out_hi_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.reply_kind    = out_kind_q;
  assign out_o.target_switch = out_id_q;
  assign out_o.rule_lo       = out_lo_q;
  assign out_o.rule_hi       = out_hi_q;
  assign out_o.out_port      = out_port_q;

  // Table reads only target present entries
  a_rd_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd.rd_en |-> is_present(tbl_cmd.rd_id, present_n))
    else $error("table read of an absent entry");

  // Table writes only come from an accepted open beat
  a_wr_on_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd.wr_en |-> (in_fire && (in_i.func == FUNC_OPEN)))
    else $error("table write outside an open beat");

  // A walk never visits more entries than the table holds
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((steps_q != '0) && (steps_q <= SW'(MAX_SWITCHES))))
    else $error("walk step count out of range");

  // A finished reply reaches the output register on the next edge
  a_reply_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (!out_valid_q || out_o.ready)) |=>
      (out_valid_q && (state_q == ST_IDLE)))
    else $error("reply not loaded into output register");

  // Forward replies always carry a port; others never do
  a_fwd_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_kind_q == KIND_FWD) == (out_port_q != PORT_NONE)))
    else $error("forward port does not match reply kind");

endmodule
